>>> src/u8cp_pkg.sv
// ----------------------------------------------------------------------------
// u8cp_pkg
// Shared types, constants and the range check for the UTF-8 decoder.
// ----------------------------------------------------------------------------
package u8cp_pkg;

  localparam int unsigned CpWidth = 21;

  localparam logic [CpWidth-1:0] Replacement = 21'h00FFFD;
  localparam logic [CpWidth-1:0] MaxScalar   = 21'h10FFFF;
  localparam logic [CpWidth-1:0] SurrLo      = 21'h00D800;
  localparam logic [CpWidth-1:0] SurrHi      = 21'h00DFFF;
  localparam logic [CpWidth-1:0] Floor2      = 21'h000080;
  localparam logic [CpWidth-1:0] Floor3      = 21'h000800;
  localparam logic [CpWidth-1:0] Floor4      = 21'h010000;

  // One result beat
  typedef struct packed {
    logic [CpWidth-1:0] code_point;
    logic               decode_error;
  } result_t;

  // Overlong, surrogate and out-of-range values become the replacement char
  function automatic logic [CpWidth-1:0] finish_value(input logic [CpWidth-1:0] v,
                                                      input logic [1:0]         conts);
    logic [CpWidth-1:0] floor_val;
    logic               bad;
    begin
      floor_val = (conts == 2'd1) ? Floor2 : (conts == 2'd2) ? Floor3 : Floor4;
      bad = (v < floor_val) || (v > MaxScalar) || ((v >= SurrLo) && (v <= SurrHi));
      finish_value = bad ? Replacement : v;
    end
  endfunction

endpackage

>>> src/u8cp_in_reg.sv
// ----------------------------------------------------------------------------
// u8cp_in_reg
// Input register: holds one byte beat until the decode stage takes it.
// ----------------------------------------------------------------------------
module u8cp_in_reg import u8cp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       load,       // register may take a new beat
  input  logic       in_valid,
  input  logic [7:0] byte_in,
  output logic       held_valid,
  output logic [7:0] held_byte
);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (load) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      held_byte <= byte_in;
    end
  end

endmodule

>>> src/u8cp_decoder.sv
// ----------------------------------------------------------------------------
// u8cp_decoder
// Sequence state and single-pass decode of one byte into at most one result.
// ----------------------------------------------------------------------------
module u8cp_decoder import u8cp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       advance,    // held byte is consumed this cycle
  input  logic [7:0] byte_val,
  output logic       res_valid,
  output result_t    res
);

  logic               halted, halted_next;
  logic [1:0]         bytes_remaining, bytes_remaining_next;
  logic [1:0]         seq_length, seq_length_next;
  logic [CpWidth-1:0] partial_value, partial_value_next;
  logic               cont_bad, cont_bad_next;

  always_comb begin
    halted_next          = halted;
    bytes_remaining_next = bytes_remaining;
    seq_length_next      = seq_length;
    partial_value_next   = partial_value;
    cont_bad_next        = cont_bad;
    res_valid            = 1'b0;
    res.code_point       = '0;
    res.decode_error     = 1'b0;

    if (!halted) begin
      if (bytes_remaining == 2'd0) begin
        cont_bad_next = 1'b0;
        if (byte_val[7] == 1'b0) begin
          res_valid      = 1'b1;
          res.code_point = {{(CpWidth-8){1'b0}}, byte_val};
        end else if (byte_val[7:5] == 3'b110) begin
          partial_value_next   = {{(CpWidth-5){1'b0}}, byte_val[4:0]};
          seq_length_next      = 2'd1;
          bytes_remaining_next = 2'd1;
        end else if (byte_val[7:4] == 4'b1110) begin
          partial_value_next   = {{(CpWidth-4){1'b0}}, byte_val[3:0]};
          seq_length_next      = 2'd2;
          bytes_remaining_next = 2'd2;
        end else if (byte_val[7:3] == 5'b11110) begin
          partial_value_next   = {{(CpWidth-3){1'b0}}, byte_val[2:0]};
          seq_length_next      = 2'd3;
          bytes_remaining_next = 2'd3;
        end else begin
          // stray continuation or F8-FF as lead
          halted_next      = 1'b1;
          res_valid        = 1'b1;
          res.decode_error = 1'b1;
        end
      end else begin
        cont_bad_next        = cont_bad | (byte_val[7:6] != 2'b10);
        partial_value_next   = {partial_value[CpWidth-7:0], byte_val[5:0]};
        bytes_remaining_next = bytes_remaining - 2'd1;
        if (bytes_remaining == 2'd1) begin
          res_valid = 1'b1;
          if (cont_bad_next) begin
            halted_next          = 1'b1;
            bytes_remaining_next = 2'd0;
            res.decode_error     = 1'b1;
          end else begin
            res.code_point = finish_value(partial_value_next, seq_length);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      halted          <= 1'b0;
      bytes_remaining <= 2'd0;
      seq_length      <= 2'd0;
      partial_value   <= '0;
      cont_bad        <= 1'b0;
    end else if (advance) begin
      halted          <= halted_next;
      bytes_remaining <= bytes_remaining_next;
      seq_length      <= seq_length_next;
      partial_value   <= partial_value_next;
      cont_bad        <= cont_bad_next;
    end
  end

endmodule

>>> src/u8cp_out_reg.sv
// ----------------------------------------------------------------------------
// u8cp_out_reg
// Result register: holds a finished beat until the consumer takes it.
// ----------------------------------------------------------------------------
module u8cp_out_reg import u8cp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  logic    res_valid,
  input  result_t res,
  input  logic    out_ready,
  output logic    out_valid,
  output result_t held
);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= res_valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res_valid) begin
      held <= res;
    end
  end

endmodule

>>> src/utf8_to_codepoint_decoder.sv
// ----------------------------------------------------------------------------
// utf8_to_codepoint_decoder
// Streaming UTF-8 to code point decoder, one byte beat per unstalled clock.
//
// Feed UTF-8 bytes in on the input channel; one code point beat comes out for
// each completed 1 to 4 byte sequence. Overlong forms, surrogates and values
// above 10FFFF come out as FFFD. A bad lead byte (80-BF, F8-FF) gives an error
// beat at once; a bad continuation byte gives an error beat when the last
// byte of its sequence arrives. After an error beat the block halts: bytes
// are still taken but nothing comes out until reset. A truncated sequence
// gives nothing. Throughput is one byte per cycle with no bubbles while no
// result beat is stalled. The edge that accepts the byte completing a result
// beat loads the input register, and the single decode pass then loads the
// result register once that register has space. Only a stalled result beat
// holds up the input, and then by a single register's worth of slack.
// ----------------------------------------------------------------------------
module utf8_to_codepoint_decoder import u8cp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         byte_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [CpWidth-1:0] code_point,
  output logic               decode_error
);

  logic       held_valid;
  logic [7:0] held_byte;
  logic       out_space;   // result register free or draining this cycle
  logic       advance;     // held byte moves through decode
  logic       res_valid;
  result_t    res;
  result_t    out_beat;

  assign out_space = !out_valid || out_ready;
  assign advance   = held_valid && out_space;
  assign in_ready  = !held_valid || out_space;

  u8cp_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .load       (in_ready),
    .in_valid   (in_valid),
    .byte_in    (byte_in),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  // State advances only when a held byte is consumed
  u8cp_decoder u_dec (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .byte_val  (held_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  // Loaded on every advance; a byte with no result leaves it empty
  u8cp_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .res_valid (res_valid),
    .res       (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .held      (out_beat)
  );

  assign code_point   = out_beat.code_point;
  assign decode_error = out_beat.decode_error;

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the UTF-8 to code point decoder.
//
// Feeds byte beats: first a short table of edge-case sequences, then about
// two thousand bytes of complete sequences with random content over four
// back-pressure phases. It ends with one random tail: a bad lead, a bad
// continuation or a truncated one, the first two trailed by noise bytes. A
// local decoder model predicts each result beat not pinned by the table, and
// a monitor checks each beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  import u8cp_pkg::*;

  // Ways the stream is allowed to end
  typedef enum int {
    TailBadLead,
    TailBadCont,
    TailTruncated
  } tail_kind_e;

  // One row of the edge-case table. Where pin is set, the result beat that
  // the byte completes is the one typed in the row.
  typedef struct packed {
    logic [7:0] b;
    bit         pin;
    result_t    want;
  } stim_row_t;

  localparam int NumRows = 25;
  localparam int PhaseBytes = 500;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [7:0]         byte_in;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [CpWidth-1:0] code_point;
  logic               decode_error;

  utf8_to_codepoint_decoder i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .byte_in      (byte_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .code_point   (code_point),
    .decode_error (decode_error)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Edge cases: ASCII extremes, smallest two-byte form, overlong leads C0/C1,
  // a surrogate, top of the BMP, top of the code space, lead F7 above range.
  // The two mid-range sequences are left to the model.
  stim_row_t edge_rows [0:NumRows-1] = '{
    '{8'h00, 1'b1, '{21'h000000, 1'b0}},
    '{8'h7F, 1'b1, '{21'h00007F, 1'b0}},
    '{8'hC2, 1'b0, '{21'h000000, 1'b0}},
    '{8'h80, 1'b1, '{21'h000080, 1'b0}},
    '{8'hC0, 1'b0, '{21'h000000, 1'b0}},
    '{8'h80, 1'b1, '{21'h00FFFD, 1'b0}},
    '{8'hC1, 1'b0, '{21'h000000, 1'b0}},
    '{8'hBF, 1'b1, '{21'h00FFFD, 1'b0}},
    '{8'hD0, 1'b0, '{21'h000000, 1'b0}},
    '{8'h9F, 1'b0, '{21'h000000, 1'b0}},
    '{8'hED, 1'b0, '{21'h000000, 1'b0}},
    '{8'hA0, 1'b0, '{21'h000000, 1'b0}},
    '{8'h80, 1'b1, '{21'h00FFFD, 1'b0}},
    '{8'hE4, 1'b0, '{21'h000000, 1'b0}},
    '{8'hB8, 1'b0, '{21'h000000, 1'b0}},
    '{8'hAD, 1'b0, '{21'h000000, 1'b0}},
    '{8'hEF, 1'b0, '{21'h000000, 1'b0}},
    '{8'hBF, 1'b0, '{21'h000000, 1'b0}},
    '{8'hBF, 1'b1, '{21'h00FFFF, 1'b0}},
    '{8'hF4, 1'b0, '{21'h000000, 1'b0}},
    '{8'h8F, 1'b0, '{21'h000000, 1'b0}},
    '{8'hBF, 1'b0, '{21'h000000, 1'b0}},
    '{8'hBF, 1'b1, '{21'h10FFFF, 1'b0}},
    '{8'hF7, 1'b0, '{21'h000000, 1'b0}},
    '{8'hBF, 1'b0, '{21'h000000, 1'b0}}
  };

  // Decoder model state
  bit                 dec_halted;
  logic [1:0]         dec_left;
  logic [1:0]         dec_conts;
  logic [CpWidth-1:0] dec_acc;
  bit                 dec_bad_cont;

  result_t            cp_expected [$];

  int idle_pct  = 0;
  int stall_pct = 0;
  int n_bytes   = 0;
  int n_results = 0;
  int n_fffd    = 0;
  int n_err     = 0;
  int n_fail    = 0;

  // Steps the model by one byte; returns 1 when the byte completes a beat.
  function automatic bit decode_byte(input logic [7:0] b, output result_t r);
    logic [CpWidth-1:0] lowest;
    r = '0;
    if (dec_halted)
      return 1'b0;
    if (dec_left == 2'd0) begin
      dec_bad_cont = 1'b0;
      if (b[7] == 1'b0) begin
        r.code_point = CpWidth'(b);
        return 1'b1;
      end
      if (b[7:5] == 3'b110) begin
        dec_acc   = CpWidth'(b[4:0]);
        dec_conts = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        dec_acc   = CpWidth'(b[3:0]);
        dec_conts = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
        dec_acc   = CpWidth'(b[2:0]);
        dec_conts = 2'd3;
      end else begin
        // stray continuation or F8-FF as a lead
        dec_halted     = 1'b1;
        r.decode_error = 1'b1;
        return 1'b1;
      end
      dec_left = dec_conts;
      return 1'b0;
    end
    // a bad continuation still counts towards the length
    if (b[7:6] != 2'b10)
      dec_bad_cont = 1'b1;
    dec_acc  = {dec_acc[CpWidth-7:0], b[5:0]};
    dec_left = dec_left - 2'd1;
    if (dec_left != 2'd0)
      return 1'b0;
    if (dec_bad_cont) begin
      dec_halted     = 1'b1;
      r.decode_error = 1'b1;
      return 1'b1;
    end
    lowest = (dec_conts == 2'd1) ? Floor2 : (dec_conts == 2'd2) ? Floor3 : Floor4;
    if (dec_acc < lowest || dec_acc > MaxScalar || (dec_acc >= SurrLo && dec_acc <= SurrHi))
      r.code_point = Replacement;
    else
      r.code_point = dec_acc;
    return 1'b1;
  endfunction

  // Lead byte for a sequence of len bytes; four-byte leads mostly in range.
  function automatic logic [7:0] lead_for(input int len);
    case (len)
      1: return 8'($urandom_range(8'h00, 8'h7F));
      2: return 8'($urandom_range(8'hC0, 8'hDF));
      3: return 8'($urandom_range(8'hE0, 8'hEF));
      default: begin
        if ($urandom_range(0, 3) == 0)
          return 8'($urandom_range(8'hF5, 8'hF7));
        return 8'($urandom_range(8'hF0, 8'hF4));
      end
    endcase
  endfunction

  function automatic logic [7:0] cont_byte();
    return {2'b10, 6'($urandom)};
  endfunction

  // Entered and left at a falling edge. The sender may idle first; the beat
  // is then held until accepted. Nothing is assigned on the edge it leaves
  // on, so a back-to-back beat can follow without touching in_valid twice.
  task automatic put_byte(input logic [7:0] b, input bit pin, input result_t want);
    result_t r;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      byte_in  <= 8'($urandom);
      @(negedge clk);
    end
    in_valid <= 1'b1;
    byte_in  <= b;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
    n_bytes++;
    if (decode_byte(b, r))
      cp_expected.push_back(pin ? want : r);
    @(negedge clk);
  endtask

  task automatic put_free(input logic [7:0] b);
    put_byte(b, 1'b0, '0);
  endtask

  // Drops valid and holds off until every predicted beat has come out
  task automatic drain();
    in_valid <= 1'b0;
    while (cp_expected.size() != 0)
      @(negedge clk);
  endtask

  task automatic put_sequence();
    int len;
    len = $urandom_range(1, 4);
    put_free(lead_for(len));
    for (int k = 1; k < len; k++)
      put_free(cont_byte());
  endtask

  // Receiver back-pressure
  always @(negedge clk)
    out_ready <= ($urandom_range(0, 99) >= stall_pct);

  // Result beat checker
  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && out_ready) begin
      n_results++;
      if (decode_error)
        n_err++;
      else if (code_point == Replacement)
        n_fffd++;
      if (cp_expected.size() == 0) begin
        $display("%0t: unexpected beat, expected none, got cp=%h err=%b",
                 $time, code_point, decode_error);
        n_fail++;
      end else begin
        want = cp_expected.pop_front();
        if (code_point !== want.code_point) begin
          $display("%0t: code_point expected %h, got %h", $time, want.code_point, code_point);
          n_fail++;
        end
        if (decode_error !== want.decode_error) begin
          $display("%0t: decode_error expected %b, got %b",
                   $time, want.decode_error, decode_error);
          n_fail++;
        end
      end
    end
  end

  initial begin
    tail_kind_e tail;
    int         len;
    int         bad_at;
    int         phase_end;
    rst      = 1'b1;
    in_valid = 1'b0;
    byte_in  = 8'h00;
    dec_halted   = 1'b0;
    dec_left     = '0;
    dec_conts    = '0;
    dec_acc      = '0;
    dec_bad_cont = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // edge-case table, no idling
    for (int i = 0; i < NumRows; i++)
      put_byte(edge_rows[i].b, edge_rows[i].pin, edge_rows[i].want);
    // finish the F7 sequence left open by the table
    put_free(8'hBF);
    put_free(8'hBF);

    // four phases of random complete sequences; the sender waits for the
    // pipe to empty between phases
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 51; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 51; end
        default: begin idle_pct = 24; stall_pct = 24; end
      endcase
      phase_end = n_bytes + PhaseBytes;
      while (n_bytes < phase_end)
        put_sequence();
      if (ph != 3)
        drain();
    end

    // ending: a broken sequence, then bytes to swallow if it halted the block
    tail = tail_kind_e'($urandom_range(0, 2));
    len  = $urandom_range(2, 4);
    case (tail)
      TailBadLead: begin
        if ($urandom_range(0, 1) == 1)
          put_free(8'($urandom_range(8'h80, 8'hBF)));
        else
          put_free(8'($urandom_range(8'hF8, 8'hFF)));
      end
      TailBadCont: begin
        bad_at = $urandom_range(1, len - 1);
        put_free(lead_for(len));
        for (int k = 1; k < len; k++) begin
          if (k != bad_at)
            put_free(cont_byte());
          else if ($urandom_range(0, 1) == 1)
            put_free(8'($urandom_range(8'h00, 8'h7F)));
          else
            put_free(8'($urandom_range(8'hC0, 8'hFF)));
        end
      end
      default: begin
        put_free(lead_for(len));
        for (int k = 1; k < $urandom_range(1, len - 1); k++)
          put_free(cont_byte());
      end
    endcase
    if (tail != TailTruncated) begin
      repeat (16)
        put_free(8'($urandom));
    end

    drain();
    repeat (20) @(posedge clk);

    if (cp_expected.size() != 0) begin
      $display("%0t: %0d predicted beats never arrived", $time, cp_expected.size());
      n_fail++;
    end
    $display("tb: %0d byte beats in, %0d result beats checked (%0d FFFD, %0d error)",
             n_bytes, n_results, n_fffd, n_err);
    $display("tb: back-pressure phases none/sender/receiver/both, ending kind %s",
             tail.name());
    if (n_fail == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("%0t: watchdog expired", $time);
    $display("tb: FAIL");
    $finish;
  end

endmodule

>>> utf8_to_codepoint_decoder.f
src/u8cp_pkg.sv
src/u8cp_in_reg.sv
src/u8cp_decoder.sv
src/u8cp_out_reg.sv
src/utf8_to_codepoint_decoder.sv
tb/tb.sv
